// ----- design/rfp_pkg.sv -----
// Shared types and constants for the e-paper refresh planner.
package rfp_pkg;

	localparam int COL_W  = 7;
	localparam int ROW_W  = 9;
	localparam int HASH_W = 32;
	localparam int CNT_W  = 16;

	localparam logic [HASH_W-1:0] HASH_BASIS = 32'd2166136261;
	localparam logic [HASH_W-1:0] HASH_PRIME = 32'd16777619;
	localparam logic [CNT_W-1:0]  LIMIT_RESET = 16'd30;
	localparam logic [CNT_W-1:0]  CNT_MAX     = 16'hFFFF;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	typedef enum logic [1:0] {
		ACT_SKIP    = 2'd0,
		ACT_FULL    = 2'd1,
		ACT_PARTIAL = 2'd2
	} action_t;

	typedef struct packed {
		logic [HASH_W-1:0] hash;
		logic [COL_W-1:0]  min_col;
		logic [COL_W-1:0]  max_col;
		logic [ROW_W-1:0]  min_row;
		logic [ROW_W-1:0]  max_row;
		logic              change;
	} frame_sum_t;

	typedef struct packed {
		logic       push;
		frame_sum_t sum;
	} q_wr_t;

	typedef struct packed {
		logic       valid;
		logic       full;
		frame_sum_t sum;
	} q_rd_t;

endpackage

// ----- design/rfp_front.sv -----
// Front end: accepts bytes, tracks position, red hash and changed-byte box.
module rfp_front #(
	parameter int COLUMNS_PER_ROW = 99,
	parameter int ROWS_PER_FRAME  = 272
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         black_byte,
	input  logic [7:0]         reference_byte,
	input  logic [7:0]         red_byte,
	input  logic               frame_end,
	input  logic               q_full,
	output rfp_pkg::q_wr_t     q_wr
);

	localparam logic [rfp_pkg::COL_W-1:0] LAST_COL  = rfp_pkg::COL_W'(COLUMNS_PER_ROW - 1);
	localparam logic [rfp_pkg::ROW_W-1:0] LAST_ROW  = rfp_pkg::ROW_W'(ROWS_PER_FRAME - 1);
	localparam logic [rfp_pkg::COL_W-1:0] COL_INIT  = rfp_pkg::COL_W'(COLUMNS_PER_ROW);
	localparam logic [rfp_pkg::ROW_W-1:0] ROW_INIT  = rfp_pkg::ROW_W'(ROWS_PER_FRAME);

	logic [rfp_pkg::COL_W-1:0]  column_q, min_col_q, max_col_q;
	logic [rfp_pkg::ROW_W-1:0]  row_q, min_row_q, max_row_q;
	logic [rfp_pkg::HASH_W-1:0] hash_q;
	logic                       change_q;

	logic                       accept;
	logic                       diff;
	logic [rfp_pkg::HASH_W-1:0] hash_next;
	rfp_pkg::frame_sum_t        sum_next;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;
	assign diff     = black_byte != reference_byte;
	assign hash_next = (hash_q ^ {24'd0, red_byte}) * rfp_pkg::HASH_PRIME;

	always_comb begin
		sum_next.hash    = hash_next;
		sum_next.min_col = (diff && column_q < min_col_q) ? column_q : min_col_q;
		sum_next.max_col = (diff && column_q > max_col_q) ? column_q : max_col_q;
		sum_next.min_row = (diff && row_q < min_row_q) ? row_q : min_row_q;
		sum_next.max_row = (diff && row_q > max_row_q) ? row_q : max_row_q;
		sum_next.change  = change_q || diff;
	end

	assign q_wr.push = accept && frame_end;
	assign q_wr.sum  = sum_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q  <= '0;
			row_q     <= '0;
			hash_q    <= rfp_pkg::HASH_BASIS;
			min_col_q <= COL_INIT;
			max_col_q <= '0;
			min_row_q <= ROW_INIT;
			max_row_q <= '0;
			change_q  <= 1'b0;
		end else if (accept) begin
			if (frame_end) begin
				column_q  <= '0;
				row_q     <= '0;
				hash_q    <= rfp_pkg::HASH_BASIS;
				min_col_q <= COL_INIT;
				max_col_q <= '0;
				min_row_q <= ROW_INIT;
				max_row_q <= '0;
				change_q  <= 1'b0;
			end else begin
				hash_q    <= sum_next.hash;
				min_col_q <= sum_next.min_col;
				max_col_q <= sum_next.max_col;
				min_row_q <= sum_next.min_row;
				max_row_q <= sum_next.max_row;
				change_q  <= sum_next.change;
				if (column_q == LAST_COL) begin
					column_q <= '0;
					row_q    <= (row_q == LAST_ROW) ? '0 : row_q + 1'b1;
				end else begin
					column_q <= column_q + 1'b1;
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		column_q <= LAST_COL && row_q <= LAST_ROW)
		else $error("front position out of frame");
	a_box_order: assert property (@(posedge clk) disable iff (!arst_n)
		change_q |-> (min_col_q <= max_col_q && min_row_q <= max_row_q))
		else $error("front box inverted after a change");
`endif

endmodule

// ----- design/rfp_queue.sv -----
// Short queue of frame summaries between front and back.
module rfp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  rfp_pkg::q_wr_t q_wr,
	input  logic           pop,
	output rfp_pkg::q_rd_t q_rd
);

	rfp_pkg::frame_sum_t          mem [rfp_pkg::Q_DEPTH];
	logic [rfp_pkg::Q_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [rfp_pkg::Q_CNT_W-1:0]  count_q;
	logic                         do_pop;

	assign do_pop     = pop && count_q != '0;
	assign q_rd.valid = count_q != '0;
	assign q_rd.full  = count_q == rfp_pkg::Q_CNT_W'(rfp_pkg::Q_DEPTH);
	assign q_rd.sum   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (q_wr.push) begin
			mem[wr_ptr_q] <= q_wr.sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (q_wr.push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({q_wr.push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd.full |-> !q_wr.push)
		else $error("queue written while full");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rfp_pkg::Q_CNT_W'(rfp_pkg::Q_DEPTH))
		else $error("queue count beyond depth");
`endif

endmodule

// ----- design/rfp_back.sv -----
// Back end: decides the refresh action per frame and holds panel history.
module rfp_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rfp_pkg::q_rd_t              q_rd,
	output logic                        pop,
	input  logic                        cfg_write,
	input  logic [rfp_pkg::CNT_W-1:0]   cfg_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  action,
	output logic [rfp_pkg::COL_W-1:0]   first_column,
	output logic [rfp_pkg::COL_W-1:0]   last_column,
	output logic [rfp_pkg::ROW_W-1:0]   first_row,
	output logic [rfp_pkg::ROW_W-1:0]   last_row,
	output logic [rfp_pkg::HASH_W-1:0]  red_checksum
);

	logic [rfp_pkg::CNT_W-1:0]  limit_q;
	logic [rfp_pkg::CNT_W-1:0]  pcount_q;
	logic [rfp_pkg::HASH_W-1:0] stored_hash_q;
	logic                       baseline_q;
	logic                       out_valid_q;
	rfp_pkg::action_t           action_q;
	logic [rfp_pkg::COL_W-1:0]  first_col_q, last_col_q;
	logic [rfp_pkg::ROW_W-1:0]  first_row_q, last_row_q;
	logic [rfp_pkg::HASH_W-1:0] checksum_q;

	rfp_pkg::action_t           act;
	logic                       is_partial;

	assign pop = q_rd.valid && (!out_valid_q || out_ready);

	always_comb begin
		if (!baseline_q || q_rd.sum.hash != stored_hash_q) begin
			act = rfp_pkg::ACT_FULL;
		end else if (!q_rd.sum.change) begin
			act = rfp_pkg::ACT_SKIP;
		end else if (pcount_q >= limit_q) begin
			act = rfp_pkg::ACT_FULL;
		end else begin
			act = rfp_pkg::ACT_PARTIAL;
		end
	end

	assign is_partial = act == rfp_pkg::ACT_PARTIAL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q       <= rfp_pkg::LIMIT_RESET;
			pcount_q      <= '0;
			stored_hash_q <= '0;
			baseline_q    <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_write) begin
				limit_q <= cfg_data;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
				case (act)
					rfp_pkg::ACT_FULL: begin
						stored_hash_q <= q_rd.sum.hash;
						baseline_q    <= 1'b1;
						pcount_q      <= '0;
					end
					rfp_pkg::ACT_PARTIAL: begin
						stored_hash_q <= q_rd.sum.hash;
						if (pcount_q != rfp_pkg::CNT_MAX) begin
							pcount_q <= pcount_q + 1'b1;
						end
					end
					default: begin
					end
				endcase
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			action_q    <= act;
			first_col_q <= is_partial ? q_rd.sum.min_col : '0;
			last_col_q  <= is_partial ? q_rd.sum.max_col : '0;
			first_row_q <= is_partial ? q_rd.sum.min_row : '0;
			last_row_q  <= is_partial ? q_rd.sum.max_row : '0;
			checksum_q  <= q_rd.sum.hash;
		end
	end

	assign out_valid    = out_valid_q;
	assign action       = action_q;
	assign first_column = first_col_q;
	assign last_column  = last_col_q;
	assign first_row    = first_row_q;
	assign last_row     = last_row_q;
	assign red_checksum = checksum_q;

`ifndef NO_ASSERTIONS
	a_full_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && act == rfp_pkg::ACT_FULL) |=> (pcount_q == '0 && baseline_q))
		else $error("full refresh did not reset partial count");
	a_box_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && action_q != rfp_pkg::ACT_PARTIAL) |->
		(first_col_q == '0 && last_col_q == '0 && first_row_q == '0 && last_row_q == '0))
		else $error("box fields set outside partial refresh");
`endif

endmodule

// ----- design/epaper_refresh_planner.sv -----
// Top level of the e-paper refresh planner: front, summary queue and back.
// The frame_end byte's summary is queued; out_valid rises when the back end pops it.
// One byte per cycle while the queue is not full; the hash is an xor-multiply recurrence.
// A frame end is taken every cycle while the two-entry summary queue has room.
// Reset (arst_n low, asynchronous): limit 30, no baseline, partial count 0, queue empty.
module epaper_refresh_planner #(
	parameter int COLUMNS_PER_ROW = 99,
	parameter int ROWS_PER_FRAME  = 272
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic [rfp_pkg::CNT_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  black_byte,
	input  logic [7:0]                  reference_byte,
	input  logic [7:0]                  red_byte,
	input  logic                        frame_end,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  action,
	output logic [rfp_pkg::COL_W-1:0]   first_column,
	output logic [rfp_pkg::COL_W-1:0]   last_column,
	output logic [rfp_pkg::ROW_W-1:0]   first_row,
	output logic [rfp_pkg::ROW_W-1:0]   last_row,
	output logic [rfp_pkg::HASH_W-1:0]  red_checksum
);

	rfp_pkg::q_wr_t q_wr;
	rfp_pkg::q_rd_t q_rd;
	logic           pop;

	rfp_front #(
		.COLUMNS_PER_ROW (COLUMNS_PER_ROW),
		.ROWS_PER_FRAME  (ROWS_PER_FRAME)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.black_byte     (black_byte),
		.reference_byte (reference_byte),
		.red_byte       (red_byte),
		.frame_end      (frame_end),
		.q_full         (q_rd.full),
		.q_wr           (q_wr)
	);

	rfp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.pop    (pop),
		.q_rd   (q_rd)
	);

	rfp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_rd         (q_rd),
		.pop          (pop),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.action       (action),
		.first_column (first_column),
		.last_column  (last_column),
		.first_row    (first_row),
		.last_row     (last_row),
		.red_checksum (red_checksum)
	);

endmodule
